/* hdl/gaussian_blur_border_renormalized_assert.svh */
// Assertion macros shared by the blur block.
`ifndef GAUSSIAN_BLUR_BORDER_RENORMALIZED_ASSERT_SVH
`define GAUSSIAN_BLUR_BORDER_RENORMALIZED_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GBR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/gbr_pkg.sv */
`timescale 1ns / 1ps

package gbr_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_FILTER_RADIUS = 3'd2;
   localparam logic [2:0] CSR_CHANNELS_USED = 3'd3;
   localparam logic [2:0] CSR_WEIGHT_CENTER = 3'd4;
   localparam logic [2:0] CSR_WEIGHT_ONE    = 3'd5;
   localparam logic [2:0] CSR_WEIGHT_TWO    = 3'd6;
   localparam logic [2:0] CSR_WEIGHT_THREE  = 3'd7;

   // Register values after reset.
   localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd640;
   localparam logic [15:0] RST_IMAGE_HEIGHT  = 16'd480;
   localparam logic [1:0]  RST_FILTER_RADIUS = 2'd2;
   localparam logic [2:0]  RST_CHANNELS_USED = 3'd4;
   localparam logic [15:0] RST_WEIGHT_CENTER = 16'd65535;
   localparam logic [15:0] RST_WEIGHT_ONE    = 16'd39749;
   localparam logic [15:0] RST_WEIGHT_TWO    = 16'd8869;
   localparam logic [15:0] RST_WEIGHT_THREE  = 16'd728;

   // Item operation codes.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Quotient bits per channel, one divider cell per bit.
   localparam int QUO_W = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAPS,
      ST_FLUSH,
      ST_LAUNCH,
      ST_DIVIDE
   } gbr_state_type;

   // Control that travels with a quotient through the divider cells.
   typedef struct packed {
      logic       valid;
      logic       frame_end;
      logic       den_zero;
      logic [2:0] nch;
   } gbr_tag_type;

endpackage

/* hdl/gaussian_blur_border_renormalized.sv */
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// req       req_valid/req_stall  req_operation, req_chan_a..req_chan_d
// rsp       rsp_valid/rsp_stall  rsp_out_a..rsp_out_d, rsp_frame_end
// csr       csr_valid/csr_ready  csr_index, csr_wdata
//
// An item that releases no result is taken in the idle state and leaves it idle. An item
// that releases a result passes its accept, the tap sequencer, which reads one line-store
// word a cycle for each tap of the window, the flush and launch states and the divider
// cells; the next item is taken once the result has left the divider cells.
// Reset is synchronous; the request side stalls after reset and after every register
// write while the frame size settles. A finished item waits in the output register;
// the next item is taken meanwhile and holds at launch until it frees.

`include "gaussian_blur_border_renormalized_assert.svh"

module gaussian_blur_border_renormalized
   import gbr_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 3,
   parameter int CHANNELS   = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_chan_a,
   input  logic [7:0]  req_chan_b,
   input  logic [7:0]  req_chan_c,
   input  logic [7:0]  req_chan_d,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_a,
   output logic [7:0]  rsp_out_b,
   output logic [7:0]  rsp_out_c,
   output logic [7:0]  rsp_out_d,
   output logic        rsp_frame_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int W_W       = $clog2(MAX_WIDTH + 1);
   localparam int POS_W     = W_W + 16;
   localparam int LINE_ROWS = 2 * MAX_RADIUS + 2;
   localparam int SLOT_W    = $clog2(LINE_ROWS);
   localparam int ADDR_W    = SLOT_W + COL_W;
   localparam int DEPTH     = LINE_ROWS * (2 ** COL_W);
   localparam int TAP_N     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int DEN_W     = 32 + $clog2(TAP_N);
   localparam int ACC_W     = DEN_W + QUO_W;
   localparam int PIX_W     = 8 * CHANNELS;
   localparam int CELLS     = QUO_W;

   // Configuration registers.
   logic [10:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic [1:0]  filter_radius_ff;
   logic [2:0]  channels_used_ff;
   logic [15:0] wtab_ff [4];
   logic        csr_write;
   logic        geometry_write;

   assign csr_write      = csr_valid && csr_ready;
   assign geometry_write = csr_write && (csr_index == CSR_IMAGE_WIDTH ||
                           csr_index == CSR_IMAGE_HEIGHT || csr_index == CSR_FILTER_RADIUS);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= RST_IMAGE_WIDTH;
         image_height_ff  <= RST_IMAGE_HEIGHT;
         filter_radius_ff <= RST_FILTER_RADIUS;
         channels_used_ff <= RST_CHANNELS_USED;
         wtab_ff[0]       <= RST_WEIGHT_CENTER;
         wtab_ff[1]       <= RST_WEIGHT_ONE;
         wtab_ff[2]       <= RST_WEIGHT_TWO;
         wtab_ff[3]       <= RST_WEIGHT_THREE;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata[10:0];
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata;
            CSR_FILTER_RADIUS: filter_radius_ff <= csr_wdata[1:0];
            CSR_CHANNELS_USED: channels_used_ff <= csr_wdata[2:0];
            CSR_WEIGHT_CENTER: wtab_ff[0]       <= csr_wdata;
            CSR_WEIGHT_ONE:    wtab_ff[1]       <= csr_wdata;
            CSR_WEIGHT_TWO:    wtab_ff[2]       <= csr_wdata;
            CSR_WEIGHT_THREE:  wtab_ff[3]       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective geometry with out-of-range values clamped.
   logic [W_W-1:0] w_eff;
   logic [15:0]    h_eff;
   logic [1:0]     rad_eff;
   logic [2:0]     nch_eff;

   always_comb begin
      if (image_width_ff == 11'd0) begin
         w_eff = W_W'(1);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = W_W'(MAX_WIDTH);
      end else begin
         w_eff = W_W'(image_width_ff);
      end
      h_eff   = (image_height_ff == 16'd0) ? 16'd1 : image_height_ff;
      rad_eff = (32'(filter_radius_ff) > 32'(MAX_RADIUS)) ? 2'(MAX_RADIUS)
                                                          : filter_radius_ff;
      if (channels_used_ff == 3'd0) begin
         nch_eff = 3'd1;
      end else if (32'(channels_used_ff) > 32'(CHANNELS)) begin
         nch_eff = 3'(CHANNELS);
      end else begin
         nch_eff = channels_used_ff;
      end
   end

   // Frame size and output lag, registered; the settle count covers their delay.
   logic [POS_W-1:0] total_ff;
   logic [POS_W-1:0] lag_ff;
   logic [1:0]       settle_ff;

   always_ff @(posedge clock) begin
      total_ff <= POS_W'(w_eff * h_eff);
      lag_ff   <= POS_W'(rad_eff * w_eff) + POS_W'(rad_eff);
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         settle_ff <= 2'd3;
      end else if (settle_ff != 2'd0) begin
         settle_ff <= settle_ff - 2'd1;
      end
   end

   // Sequencer state and handshake control.
   gbr_state_type state_ff;
   gbr_state_type state_in;
   logic          req_accept;
   logic          due;
   logic          tap_active;
   logic          tap_last;
   logic          flush_ff;
   logic          launch_go;
   logic          rsp_valid_ff;
   gbr_tag_type   c_tag [CELLS+1];

   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_accept && due) state_in = ST_TAPS;
         ST_TAPS:   if (tap_last) state_in = ST_FLUSH;
         ST_FLUSH:  if (flush_ff) state_in = ST_LAUNCH;
         ST_LAUNCH: if (!rsp_valid_ff) state_in = ST_DIVIDE;
         ST_DIVIDE: if (c_tag[CELLS].valid) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != ST_IDLE) || (settle_ff != 2'd0);
      csr_ready  = (state_ff == ST_IDLE);
      tap_active = (state_ff == ST_TAPS);
      launch_go  = (state_ff == ST_LAUNCH) && !rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         flush_ff <= (state_ff == ST_FLUSH) && !flush_ff;
      end
   end

   // Input and output positions of the frame.
   logic [POS_W-1:0]  in_pos_ff, in_pos_in, out_pos_ff, out_pos_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic [15:0]       out_row_ff, out_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [15:0]       cur_row_ff, cur_row_in;
   logic              cur_end_ff, cur_end_in;
   logic              pix_write;
   logic [POS_W-1:0]  in_next;
   logic              frame_done;

   assign pix_write  = req_accept && (req_operation == OP_PIXEL) && (in_pos_ff < total_ff);
   assign in_next    = in_pos_ff + POS_W'(pix_write);
   assign due        = (in_next == total_ff) ||
                       ({1'b0, in_next} > ({1'b0, out_pos_ff} + {1'b0, lag_ff}));
   assign frame_done = (out_pos_ff == total_ff - POS_W'(1));

   always_comb begin
      in_pos_in   = in_pos_ff;
      in_col_in   = in_col_ff;
      in_slot_in  = in_slot_ff;
      out_pos_in  = out_pos_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      cur_slot_in = cur_slot_ff;
      cur_end_in  = cur_end_ff;
      // Pixel write advances the input raster position.
      if (pix_write) begin
         in_pos_in = in_next;
         if (32'(in_col_ff) == 32'(w_eff) - 1) begin
            in_col_in  = '0;
            in_slot_in = (32'(in_slot_ff) == LINE_ROWS - 1) ? '0
                                                            : in_slot_ff + SLOT_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end
      // A due result captures the output position and advances it.
      if (req_accept && due) begin
         cur_col_in  = out_col_ff;
         cur_row_in  = out_row_ff;
         cur_slot_in = out_slot_ff;
         cur_end_in  = frame_done;
         out_pos_in  = out_pos_ff + POS_W'(1);
         if (32'(out_col_ff) == 32'(w_eff) - 1) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + 16'd1;
            out_slot_in = (32'(out_slot_ff) == LINE_ROWS - 1) ? '0
                                                              : out_slot_ff + SLOT_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
      // The frame restarts after its last result or on a geometry change.
      if ((req_accept && due && frame_done) || geometry_write) begin
         in_pos_in   = '0;
         in_col_in   = '0;
         in_slot_in  = '0;
         out_pos_in  = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         out_slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pos_ff   <= '0;
         in_col_ff   <= '0;
         in_slot_ff  <= '0;
         out_pos_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
      end else begin
         in_pos_ff   <= in_pos_in;
         in_col_ff   <= in_col_in;
         in_slot_ff  <= in_slot_in;
         out_pos_ff  <= out_pos_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff  <= cur_col_in;
      cur_row_ff  <= cur_row_in;
      cur_slot_ff <= cur_slot_in;
      cur_end_ff  <= cur_end_in;
   end

   // Tap counters walk the window row by row.
   logic [2:0] ty_ff, ty_in, tx_ff, tx_in;
   logic [2:0] span;

   assign span     = {rad_eff, 1'b0};
   assign tap_last = tap_active && (ty_ff == span) && (tx_ff == span);

   always_comb begin
      ty_in = ty_ff;
      tx_in = tx_ff;
      if (!tap_active) begin
         ty_in = 3'd0;
         tx_in = 3'd0;
      end else if (tx_ff == span) begin
         tx_in = 3'd0;
         ty_in = ty_ff + 3'd1;
      end else begin
         tx_in = tx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ty_ff <= 3'd0;
         tx_ff <= 3'd0;
      end else begin
         ty_ff <= ty_in;
         tx_ff <= tx_in;
      end
   end

   // Tap geometry: image bounds, ring slot and weight indexes.
   logic signed [4:0]        dy, dx;
   logic signed [17:0]       row_s;
   logic signed [COL_W+1:0]  col_s;
   logic signed [SLOT_W+1:0] slot_s;
   logic [SLOT_W-1:0]        slot_w;
   logic                     tap_inside;
   logic [4:0]               ay_full, ax_full;
   logic [ADDR_W-1:0]        rd_addr, wr_addr;
   logic [31:0]              wt_prod;

   always_comb begin
      dy      = $signed({2'b00, ty_ff}) - $signed({3'b000, rad_eff});
      dx      = $signed({2'b00, tx_ff}) - $signed({3'b000, rad_eff});
      row_s   = $signed({2'b00, cur_row_ff}) + 18'(dy);
      col_s   = $signed({2'b00, cur_col_ff}) + (COL_W+2)'(dx);
      slot_s  = $signed({2'b00, cur_slot_ff}) + (SLOT_W+2)'(dy);
      if (slot_s < 0) begin
         slot_w = SLOT_W'(slot_s + (SLOT_W+2)'(LINE_ROWS));
      end else if (slot_s >= (SLOT_W+2)'(LINE_ROWS)) begin
         slot_w = SLOT_W'(slot_s - (SLOT_W+2)'(LINE_ROWS));
      end else begin
         slot_w = SLOT_W'(slot_s);
      end
      tap_inside = !row_s[17] && (row_s[16:0] < {1'b0, h_eff}) &&
                   !col_s[COL_W+1] && (32'(col_s[COL_W:0]) < 32'(w_eff));
      ay_full = dy[4] ? -dy : dy;
      ax_full = dx[4] ? -dx : dx;
      rd_addr = {slot_w, col_s[COL_W-1:0]};
      wr_addr = {in_slot_ff, in_col_ff};
      wt_prod = {16'd0, wtab_ff[ay_full[1:0]]} * {16'd0, wtab_ff[ax_full[1:0]]};
   end

   // Line store: ring of rows, written on pixel items, read one tap a cycle.
   logic [PIX_W-1:0] line_mem [DEPTH];
   logic [PIX_W-1:0] mem_q_ff;
   logic [7:0]       req_byte [4];
   logic [PIX_W-1:0] pix_data;

   assign req_byte[0] = req_chan_a;
   assign req_byte[1] = req_chan_b;
   assign req_byte[2] = req_chan_c;
   assign req_byte[3] = req_chan_d;

   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         pix_data[8*k +: 8] = req_byte[k];
      end
   end

   always_ff @(posedge clock) begin
      if (pix_write) begin
         line_mem[wr_addr] <= pix_data;
      end
      mem_q_ff <= line_mem[rd_addr];
   end

   // Weight and product pipeline, then exact accumulation.
   logic             p1_valid_ff, p2_valid_ff;
   logic [31:0]      p1_wt_ff, p2_wt_ff;
   logic [39:0]      p2_prod_ff [CHANNELS];
   logic [39:0]      p2_prod_in [CHANNELS];
   logic [ACC_W-1:0] acc_ff [CHANNELS];
   logic [ACC_W-1:0] acc_in [CHANNELS];
   logic [DEN_W-1:0] den_ff, den_in;

   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         p2_prod_in[k] = 40'(p1_wt_ff) * 40'(mem_q_ff[8*k +: 8]);
      end
   end

   always_comb begin
      acc_in = acc_ff;
      den_in = den_ff;
      if (req_accept && due) begin
         for (int k = 0; k < CHANNELS; k++) begin
            acc_in[k] = '0;
         end
         den_in = '0;
      end else if (p2_valid_ff) begin
         for (int k = 0; k < CHANNELS; k++) begin
            acc_in[k] = acc_ff[k] + ACC_W'(p2_prod_ff[k]);
         end
         den_in = den_ff + DEN_W'(p2_wt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= tap_active && tap_inside;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_wt_ff   <= wt_prod;
      p2_wt_ff   <= p1_wt_ff;
      p2_prod_ff <= p2_prod_in;
      acc_ff     <= acc_in;
      den_ff     <= den_in;
   end

   // Divider: a row of cells, each settling one quotient bit.
   logic [DEN_W-1:0] c_den [CELLS+1];
   logic [ACC_W-1:0] c_rem [CELLS+1][CHANNELS];
   logic [QUO_W-1:0] c_quo [CELLS+1][CHANNELS];
   logic [CELLS-1:0] chain_valid;

   always_comb begin
      c_tag[0].valid     = launch_go;
      c_tag[0].frame_end = cur_end_ff;
      c_tag[0].den_zero  = (den_ff == '0);
      c_tag[0].nch       = nch_eff;
      c_den[0]           = den_ff;
      c_rem[0]           = acc_ff;
      for (int k = 0; k < CHANNELS; k++) begin
         c_quo[0][k] = '0;
      end
   end

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      gbr_div_cell #(
         .ACC_W (ACC_W),
         .DEN_W (DEN_W),
         .LANES (CHANNELS),
         .BIT   (CELLS - 1 - i)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .tag_i (c_tag[i]),
         .den_i (c_den[i]),
         .rem_i (c_rem[i]),
         .quo_i (c_quo[i]),
         .tag_o (c_tag[i+1]),
         .den_o (c_den[i+1]),
         .rem_o (c_rem[i+1]),
         .quo_o (c_quo[i+1])
      );
      assign chain_valid[i] = c_tag[i+1].valid;
   end

   // Output register: unused channels and an all-zero weight sum give zero.
   logic [7:0] rsp_byte_in [4];
   logic [7:0] rsp_byte_ff [4];
   logic       rsp_end_ff;

   for (genvar k = 0; k < 4; k++) begin : g_out
      if (k < CHANNELS) begin : g_used
         assign rsp_byte_in[k] = (3'(k) < c_tag[CELLS].nch && !c_tag[CELLS].den_zero)
                                 ? c_quo[CELLS][k] : 8'd0;
      end else begin : g_none
         assign rsp_byte_in[k] = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_tag[CELLS].valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (c_tag[CELLS].valid) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_end_ff  <= c_tag[CELLS].frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_a     = rsp_byte_ff[0];
   assign rsp_out_b     = rsp_byte_ff[1];
   assign rsp_out_c     = rsp_byte_ff[2];
   assign rsp_out_d     = rsp_byte_ff[3];
   assign rsp_frame_end = rsp_end_ff;

   // Checks on the sequencer and the divider row.
   `GBR_ASSERT_NOW(a_land_free, clock, reset, c_tag[CELLS].valid, !rsp_valid_ff, "result lands on a full output register")
   `GBR_ASSERT_NOW(a_one_in_row, clock, reset, 1'b1, $onehot0(chain_valid), "more than one item in the divider row")
   `GBR_ASSERT_NEXT(a_launch, clock, reset, launch_go, state_ff == ST_DIVIDE, "launch did not enter divide")
   `GBR_ASSERT_NOW(a_out_bound, clock, reset, settle_ff == 2'd0, out_pos_ff < total_ff, "output position past frame end")

endmodule

/* hdl/gbr_div_cell.sv */
`timescale 1ns / 1ps

module gbr_div_cell
   import gbr_pkg::*;
#(
   parameter int ACC_W = 46,
   parameter int DEN_W = 38,
   parameter int LANES = 4,
   parameter int BIT   = 7
)
(
   input  logic              clock,
   input  logic              reset,
   input  gbr_tag_type       tag_i,
   input  logic [DEN_W-1:0]  den_i,
   input  logic [ACC_W-1:0]  rem_i [LANES],
   input  logic [QUO_W-1:0]  quo_i [LANES],
   output gbr_tag_type       tag_o,
   output logic [DEN_W-1:0]  den_o,
   output logic [ACC_W-1:0]  rem_o [LANES],
   output logic [QUO_W-1:0]  quo_o [LANES]
);

   gbr_tag_type      tag_ff;
   logic [DEN_W-1:0] den_ff;
   logic [ACC_W-1:0] rem_ff [LANES];
   logic [QUO_W-1:0] quo_ff [LANES];
   logic [ACC_W-1:0] rem_in [LANES];
   logic [QUO_W-1:0] quo_in [LANES];
   logic [ACC_W-1:0] den_sh;

   // One restoring step per lane: try to take the shifted divisor off.
   assign den_sh = ACC_W'(den_i) << BIT;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         rem_in[k] = rem_i[k];
         quo_in[k] = quo_i[k];
         if (rem_i[k] >= den_sh) begin
            rem_in[k]      = rem_i[k] - den_sh;
            quo_in[k][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_i;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign tag_o = tag_ff;
   assign den_o = den_ff;
   assign rem_o = rem_ff;
   assign quo_o = quo_ff;

endmodule

/* bench/gbr_checker.sv */
`timescale 1ns / 1ps

// Watches the four channels, predicts every blurred pixel and compares it
// with what the block delivers.
module gbr_checker
   import gbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_chan_a,
   input  logic [7:0]  req_chan_b,
   input  logic [7:0]  req_chan_c,
   input  logic [7:0]  req_chan_d,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_a,
   input  logic [7:0]  rsp_out_b,
   input  logic [7:0]  rsp_out_c,
   input  logic [7:0]  rsp_out_d,
   input  logic        rsp_frame_end,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   localparam int LINE_W    = 1024;
   localparam int LINE_ROWS = 8;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
      logic [7:0] d;
      logic       frame_end;
   } blurred_px_type;

   // Shadow copy of the registers and of the streaming state.
   logic [10:0] width_reg;
   logic [15:0] height_reg;
   logic [1:0]  radius_reg;
   logic [2:0]  chans_reg;
   logic [15:0] weight_1d [4];
   logic [31:0] line_mem [LINE_ROWS * LINE_W];
   int unsigned pixels_in;
   int unsigned pixels_out;
   blurred_px_type blurred_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_W) return LINE_W;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   function automatic int unsigned eff_chans();
      if (chans_reg == 0) return 1;
      if (chans_reg > 4) return 4;
      return chans_reg;
   endfunction

   // Border-renormalized weighted average of the window around one pixel.
   function automatic blurred_px_type blur_pixel(int unsigned pos, int unsigned w,
                                                 int unsigned h);
      int row, col, rr, cc, rad;
      longint unsigned acc [4];
      longint unsigned den, wt;
      logic [31:0] px;
      logic [7:0] q [4];
      blurred_px_type res;
      rad = radius_reg;
      row = pos / w;
      col = pos % w;
      den = 0;
      for (int k = 0; k < 4; k++) acc[k] = 0;
      for (int dy = -rad; dy <= rad; dy++) begin
         rr = row + dy;
         if (rr < 0 || rr >= int'(h)) continue;
         for (int dx = -rad; dx <= rad; dx++) begin
            cc = col + dx;
            if (cc < 0 || cc >= int'(w)) continue;
            wt = longint'(weight_1d[dy < 0 ? -dy : dy]) *
                 longint'(weight_1d[dx < 0 ? -dx : dx]);
            px = line_mem[(rr % LINE_ROWS) * LINE_W + (cc % LINE_W)];
            den += wt;
            for (int k = 0; k < 4; k++) acc[k] += wt * px[8*k +: 8];
         end
      end
      for (int k = 0; k < 4; k++) begin
         if (k < eff_chans() && den != 0) q[k] = 8'(acc[k] / den);
         else q[k] = 8'd0;
      end
      res.a = q[0];
      res.b = q[1];
      res.c = q[2];
      res.d = q[3];
      res.frame_end = 1'b0;
      return res;
   endfunction

   // Advances the stream by one accepted item and queues any pixel it releases.
   task automatic accept_item(logic op, logic [31:0] px);
      int unsigned w, h, total, lag;
      blurred_px_type res;
      w = eff_width();
      h = eff_height();
      total = w * h;
      lag = radius_reg * w + radius_reg;
      if (pixels_in > total || pixels_out >= total) begin
         pixels_in  = 0;
         pixels_out = 0;
      end
      if (op == OP_PIXEL && pixels_in < total) begin
         line_mem[((pixels_in / w) % LINE_ROWS) * LINE_W + (pixels_in % w)] = px;
         pixels_in++;
      end
      if (pixels_out < total && (pixels_in == total || pixels_in > pixels_out + lag)) begin
         res = blur_pixel(pixels_out, w, h);
         res.frame_end = (pixels_out == total - 1);
         blurred_q.push_back(res);
         pixels_out++;
         if (pixels_out == total) begin
            pixels_in  = 0;
            pixels_out = 0;
         end
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
         CSR_IMAGE_WIDTH: begin
            width_reg = data[10:0];
            pixels_in = 0;
            pixels_out = 0;
         end
         CSR_IMAGE_HEIGHT: begin
            height_reg = data;
            pixels_in = 0;
            pixels_out = 0;
         end
         CSR_FILTER_RADIUS: begin
            radius_reg = data[1:0];
            pixels_in = 0;
            pixels_out = 0;
         end
         CSR_CHANNELS_USED: chans_reg = data[2:0];
         CSR_WEIGHT_CENTER: weight_1d[0] = data;
         CSR_WEIGHT_ONE:    weight_1d[1] = data;
         CSR_WEIGHT_TWO:    weight_1d[2] = data;
         CSR_WEIGHT_THREE:  weight_1d[3] = data;
         default: ;
      endcase
   endtask

   task automatic compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      blurred_px_type exp_px;
      if (reset) begin
         width_reg    = RST_IMAGE_WIDTH;
         height_reg   = RST_IMAGE_HEIGHT;
         radius_reg   = RST_FILTER_RADIUS;
         chans_reg    = RST_CHANNELS_USED;
         weight_1d[0] = RST_WEIGHT_CENTER;
         weight_1d[1] = RST_WEIGHT_ONE;
         weight_1d[2] = RST_WEIGHT_TWO;
         weight_1d[3] = RST_WEIGHT_THREE;
         pixels_in    = 0;
         pixels_out   = 0;
         blurred_q.delete();
      end else begin
         // Results first: an expectation is always queued before its result appears.
         if (rsp_valid && !rsp_stall) begin
            if (blurred_q.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %0d %0d %0d %0d %0d",
                        $time, rsp_out_a, rsp_out_b, rsp_out_c, rsp_out_d, rsp_frame_end);
               fail_count++;
            end else begin
               exp_px = blurred_q.pop_front();
               compare_field("out_a", exp_px.a, rsp_out_a);
               compare_field("out_b", exp_px.b, rsp_out_b);
               compare_field("out_c", exp_px.c, rsp_out_c);
               compare_field("out_d", exp_px.d, rsp_out_d);
               compare_field("frame_end", 8'(exp_px.frame_end), 8'(rsp_frame_end));
            end
         end
         if (csr_valid && csr_ready) write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            accept_item(req_operation,
                        {req_chan_d, req_chan_c, req_chan_b, req_chan_a});
      end
      pending = blurred_q.size();
   end

endmodule

/* bench/tb_gaussian_blur_border_renormalized.sv */
`timescale 1ns / 1ps

module tb_gaussian_blur_border_renormalized;
   import gbr_pkg::*;

   localparam int CYCLE_LIMIT  = 3000000;
   localparam int SETTLE_WAIT  = 100;
   localparam int RANDOM_ITEMS = 900;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_PIXEL;
   logic [7:0]  req_chan_a = '0;
   logic [7:0]  req_chan_b = '0;
   logic [7:0]  req_chan_c = '0;
   logic [7:0]  req_chan_d = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_a, rsp_out_b, rsp_out_c, rsp_out_d;
   logic        rsp_frame_end;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [15:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int cycles = 0;
   int burst_left = 0;
   int item_count = 0;
   bit long_hold_req = 0;
   bit long_hold_done = 0;
   int unsigned cur_w, cur_h, cur_r;

   gaussian_blur_border_renormalized dut (.*);

   gbr_checker checker_inst (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: stretches of differing stall density, and one long hold-off.
   initial begin
      int stretch, mode;
      @(negedge reset);
      forever begin
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1;
            rsp_stall <= 1'b1;
            repeat (500) @(posedge clock);
         end
         stretch = $urandom_range(20, 200);
         mode = $urandom_range(0, 3);
         repeat (stretch) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
            @(posedge clock);
         end
      end
   end

   // Offers one item in bursts with random gaps, returning at its acceptance edge.
   task automatic send_item(logic op, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                            logic [7:0] d);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= op;
      req_chan_a <= a;
      req_chan_b <= b;
      req_chan_c <= c;
      req_chan_d <= d;
      do @(posedge clock); while (req_stall);
      item_count++;
   endtask

   // Holds the sender until every expected pixel has come and the block settles.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Writes every register; unused upper data bits are randomized.
   task automatic configure(logic [10:0] w, logic [15:0] h, logic [1:0] r, logic [2:0] ch,
                            logic [15:0] w0, logic [15:0] w1, logic [15:0] w2,
                            logic [15:0] w3);
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, {5'($urandom), w});
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_write(CSR_FILTER_RADIUS, {14'($urandom), r});
      csr_write(CSR_CHANNELS_USED, {13'($urandom), ch});
      csr_write(CSR_WEIGHT_CENTER, w0);
      csr_write(CSR_WEIGHT_ONE, w1);
      csr_write(CSR_WEIGHT_TWO, w2);
      csr_write(CSR_WEIGHT_THREE, w3);
      cur_w = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
      cur_h = (h == 0) ? 1 : h;
      cur_r = r;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Streams whole frames: pixels with the odd early drain, then the flush tail.
   task automatic run_frames(int nframes);
      int unsigned total, lag, released, tail;
      total = cur_w * cur_h;
      lag = cur_r * cur_w + cur_r;
      released = 0;
      for (int unsigned k = 1; k <= total; k++)
         if (k == total || k > released + lag) released++;
      tail = total - released;
      repeat (nframes) begin
         for (int unsigned p = 0; p < total; p++) begin
            if ($urandom_range(0, 15) == 0)
               send_item(OP_DRAIN, pick_byte(), pick_byte(), pick_byte(), pick_byte());
            send_item(OP_PIXEL, pick_byte(), pick_byte(), pick_byte(), pick_byte());
         end
         // A pixel offered once the frame is complete only flushes.
         repeat (tail)
            send_item(($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN,
                      pick_byte(), pick_byte(), pick_byte(), pick_byte());
      end
   endtask

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int start_count, rand_w, rand_h;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: small frame, then the geometry and weight extremes.
      configure(11'd4, 16'd3, 2'd1, 3'd4, RST_WEIGHT_CENTER, RST_WEIGHT_ONE,
                RST_WEIGHT_TWO, RST_WEIGHT_THREE);
      run_frames(1);
      configure(11'd1, 16'd1, 2'd3, 3'd4, RST_WEIGHT_CENTER, RST_WEIGHT_ONE,
                RST_WEIGHT_TWO, RST_WEIGHT_THREE);
      run_frames(1);
      configure(11'd0, 16'd0, 2'd0, 3'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      run_frames(2);
      configure(11'd5, 16'd4, 2'd2, 3'd4, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      run_frames(1);
      configure(11'd3, 16'd6, 2'd1, 3'd2, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_frames(1);
      configure(11'd7, 16'd5, 2'd2, 3'd7, pick_weight(), pick_weight(), pick_weight(),
                pick_weight());
      run_frames(1);

      // Random settings, mostly small frames; the odd wide frame is a single row.
      start_count = item_count;
      while (item_count - start_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) begin
            rand_w = $urandom_range(40, 200);
            rand_h = 1;
         end else begin
            rand_w = $urandom_range(0, 12);
            rand_h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
         end
         configure(11'(rand_w), 16'(rand_h), 2'($urandom), 3'($urandom), pick_weight(),
                   pick_weight(), pick_weight(), pick_weight());
         long_hold_req = 1;
         run_frames($urandom_range(1, 2));
      end

      wait_idle();
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
